// ===== rtl/core/bsfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_pkg: shared types and constants
// Byte classes, result kinds, register indexes and the queue word format
// for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [BYTE_W-1:0] ESC_FLIP = 8'h20;

  localparam logic [BYTE_W-1:0] START_RESET  = 8'h5E;
  localparam logic [BYTE_W-1:0] END_RESET    = 8'h5F;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h5D;

  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd2;

  typedef enum logic [1:0] {
    CLS_START,
    CLS_END,
    CLS_ESC,
    CLS_DATA
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] end_marker;
    logic [BYTE_W-1:0] escape_marker;
  } markers_t;

endpackage : bsfr_pkg
`default_nettype wire

// ===== rtl/core/bsfr_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_classify: front end
// Sorts each received byte into start, end, escape or data by the marker
// registers, in that order of precedence.
// ----------------------------------------------------------------------------
module bsfr_classify (
  input  wire logic [bsfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire bsfr_pkg::markers_t          markers,
  output bsfr_pkg::item_t                  item
);
  import bsfr_pkg::*;

  always_comb begin
    item.data = rx_byte;
    if (rx_byte == markers.start_marker) begin
      item.cls = CLS_START;
    end else if (rx_byte == markers.end_marker) begin
      item.cls = CLS_END;
    end else if (rx_byte == markers.escape_marker) begin
      item.cls = CLS_ESC;
    end else begin
      item.cls = CLS_DATA;
    end
  end

endmodule : bsfr_classify
`default_nettype wire

// ===== rtl/core/bsfr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_fifo: two-entry queue
// Holds classified words between the front end and the frame engine.
// ----------------------------------------------------------------------------
module bsfr_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bsfr_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output bsfr_pkg::item_t      pop_item,
  output logic                 empty
);
  import bsfr_pkg::*;

  item_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule : bsfr_fifo
`default_nettype wire

// ===== rtl/core/bsfr_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_engine: frame engine
// Tracks frame, escape and byte count, unescapes data and drives the
// registered result word.
// ----------------------------------------------------------------------------
module bsfr_engine #(
  parameter int unsigned MAX_FRAME_BYTES = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire bsfr_pkg::item_t             q_item,
  output logic                             q_pop,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic [bsfr_pkg::KIND_W-1:0]      res_kind,
  output logic [bsfr_pkg::BYTE_W-1:0]      res_payload,
  output logic [bsfr_pkg::POS_W-1:0]       res_position
);
  import bsfr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

  logic               in_frame_r, in_frame_nxt;
  logic               esc_r, esc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               valid_r, valid_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [BYTE_W-1:0]  payload_r, payload_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               emit;
  logic [CNT_W+POS_W-1:0] cnt_wide;
  logic [BYTE_W-1:0]  data_byte;

  assign q_pop    = !q_empty && (!valid_r || res_ready);
  assign cnt_wide = {{POS_W{1'b0}}, cnt_r};
  assign data_byte = esc_r ? (q_item.data ^ ESC_FLIP) : q_item.data;

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    cnt_nxt      = cnt_r;
    emit         = 1'b0;
    kind_nxt     = kind_r;
    payload_nxt  = payload_r;
    pos_nxt      = pos_r;
    if (q_pop) begin
      if (q_item.cls == CLS_START) begin
        in_frame_nxt = 1'b1;
        esc_nxt      = 1'b0;
        cnt_nxt      = '0;
      end else if (in_frame_r) begin
        case (q_item.cls)
          CLS_END: begin
            emit         = 1'b1;
            kind_nxt     = KIND_DONE;
            payload_nxt  = '0;
            pos_nxt      = cnt_wide[POS_W-1:0];
            in_frame_nxt = 1'b0;
            esc_nxt      = 1'b0;
            cnt_nxt      = '0;
          end
          CLS_ESC: begin
            if (esc_r) begin
              emit         = 1'b1;
              kind_nxt     = KIND_ABORT;
              payload_nxt  = '0;
              pos_nxt      = '0;
              in_frame_nxt = 1'b0;
              esc_nxt      = 1'b0;
              cnt_nxt      = '0;
            end else begin
              esc_nxt = 1'b1;
            end
          end
          CLS_DATA: begin
            emit    = 1'b1;
            esc_nxt = 1'b0;
            if (cnt_r == MAX_CNT) begin
              kind_nxt     = KIND_ABORT;
              payload_nxt  = '0;
              pos_nxt      = '0;
              in_frame_nxt = 1'b0;
              cnt_nxt      = '0;
            end else begin
              kind_nxt    = KIND_PAYLOAD;
              payload_nxt = data_byte;
              pos_nxt     = cnt_wide[POS_W-1:0];
              cnt_nxt     = cnt_r + CNT_W'(1);
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      cnt_r      <= '0;
      valid_r    <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      cnt_r      <= cnt_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    payload_r <= payload_nxt;
    pos_r     <= pos_nxt;
  end

  assign res_valid    = valid_r;
  assign res_kind     = kind_r;
  assign res_payload  = payload_r;
  assign res_position = pos_r;

endmodule : bsfr_engine
`default_nettype wire

// ===== rtl/core/byte_stuffed_frame_receiver_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_top: byte-stuffed frame receiver
// Deframes a raw byte stream with start, end and escape markers.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue is not full; a word that yields
// a result waits in the queue, then the frame engine registers the result
// and drives the output from that register, held while the output stalls.
// The frame engine retires one queued word per cycle while the output side
// keeps taking words. Results: payload bytes with their index, frame done
// with its length, or frame aborted on a double escape or a frame longer
// than MAX_FRAME_BYTES. Marker registers must be written through the cfg
// port only while no word is in flight; the block does not enforce this.
module byte_stuffed_frame_receiver_top #(
  parameter int unsigned MAX_FRAME_BYTES = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [bsfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]         cfg_wdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]         in_tdata,   // rx_byte[7:0]
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [bsfr_pkg::OUT_DATA_W-1:0]          out_tdata,  // payload[7:0], position[18:8]
  output logic [bsfr_pkg::KIND_W-1:0]              out_tuser   // kind[1:0]
);
  import bsfr_pkg::*;

  markers_t          markers_r, markers_nxt;
  item_t             cls_item;
  item_t             q_item;
  logic              q_full, q_empty, q_pop;
  logic [BYTE_W-1:0] res_payload;
  logic [POS_W-1:0]  res_position;

  always_comb begin
    markers_nxt = markers_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_START:  markers_nxt.start_marker  = cfg_wdata;
        REG_END:    markers_nxt.end_marker    = cfg_wdata;
        REG_ESCAPE: markers_nxt.escape_marker = cfg_wdata;
        default:    markers_nxt = markers_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      markers_r.start_marker  <= START_RESET;
      markers_r.end_marker    <= END_RESET;
      markers_r.escape_marker <= ESCAPE_RESET;
    end else begin
      markers_r <= markers_nxt;
    end
  end

  bsfr_classify u_classify (
    .rx_byte (in_tdata),
    .markers (markers_r),
    .item    (cls_item)
  );

  assign in_tready = !q_full;

  bsfr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  bsfr_engine #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res_kind     (out_tuser),
    .res_payload  (res_payload),
    .res_position (res_position)
  );

  assign out_tdata = {{(OUT_DATA_W - POS_W - BYTE_W){1'b0}}, res_position, res_payload};

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_PAYLOAD || out_tuser == KIND_DONE ||
                    out_tuser == KIND_ABORT))
    else $error("illegal result kind");

  a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_ABORT) |-> (out_tdata == '0))
    else $error("abort word carries data");

  a_done_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_DONE) |-> (out_tdata[BYTE_W-1:0] == '0))
    else $error("done word carries a payload byte");

  a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && out_tvalid) |-> out_tready)
    else $error("queue popped into a stalled output");

endmodule : byte_stuffed_frame_receiver_top
`default_nettype wire
